// File: rtl/core/mlr_pkg.sv
package mlr_pkg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        OCT_X_DOWN = 2'd0,
        OCT_Y_DOWN = 2'd1,
        OCT_X_UP   = 2'd2,
        OCT_Y_UP   = 2'd3
    } octant_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FIRST = 2'd1,
        ST_RUN   = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic blank;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic last_cur;
        logic last_adv;
    } dp_status_t;

endpackage

// File: rtl/core/mlr_ctrl.sv
module mlr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    output logic                m_valid,
    input  logic                m_ready,
    output mlr_pkg::dp_cmd_t    cmd,
    input  mlr_pkg::dp_status_t status
);
    import mlr_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;
        cmd            = '0;
        if (accept) begin
            if (s_opcode == OP_LOAD) begin
                cmd.load   = 1'b1;
                state_next = ST_FIRST;
            end else begin
                cmd.emit       = 1'b1;
                out_valid_next = 1'b1;
                case (state_reg)
                    ST_IDLE: begin
                        cmd.blank = 1'b1;
                    end
                    ST_FIRST: begin
                        state_next = status.last_cur ? ST_IDLE : ST_RUN;
                    end
                    ST_RUN: begin
                        cmd.advance = 1'b1;
                        state_next  = status.last_adv ? ST_IDLE : ST_RUN;
                    end
                    default: begin
                        cmd.blank  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/core/mlr_dp.sv
module mlr_dp #(
    parameter int COORD_BITS = 10
) (
    input  logic                    aclk,
    input  mlr_pkg::dp_cmd_t        cmd,
    output mlr_pkg::dp_status_t     status,
    input  logic [COORD_BITS-1:0]   x_first,
    input  logic [COORD_BITS-1:0]   y_first,
    input  logic [COORD_BITS-1:0]   x_second,
    input  logic [COORD_BITS-1:0]   y_second,
    output logic [COORD_BITS-1:0]   pixel_x,
    output logic [COORD_BITS-1:0]   pixel_y,
    output logic                    pixel_valid,
    output logic                    last_pixel
);
    import mlr_pkg::*;

    localparam int DW = COORD_BITS + 4;
    localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

    logic [COORD_BITS-1:0] cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    logic [COORD_BITS-1:0] run_reg, rise_reg;
    logic signed [DW-1:0]  dec_reg;
    octant_t               oct_reg;

    logic [COORD_BITS-1:0] pix_x_reg, pix_y_reg;
    logic                  pix_valid_reg, pix_last_reg;

    // load path
    logic                  swap_x, swap_y;
    logic [COORD_BITS-1:0] xa, ya, xb, yb, ya_v, yb_v;
    logic [COORD_BITS-1:0] run_next, rise_next;
    octant_t               oct_next;
    logic signed [DW-1:0]  run_ext, rise_ext, dec_load;

    // step path
    logic                  x_major, diag, step_last;
    logic [COORD_BITS-1:0] adv_x, adv_y, step_x, step_y;
    logic signed [DW-1:0]  cur_run, cur_rise, dec_adv;

    always_comb begin
        swap_x = x_first > x_second;
        xa     = swap_x ? x_second : x_first;
        ya     = swap_x ? y_second : y_first;
        xb     = swap_x ? x_first  : x_second;
        yb     = swap_x ? y_first  : y_second;
        swap_y = (xa == xb) && (ya < yb);
        ya_v   = swap_y ? yb : ya;
        yb_v   = swap_y ? ya : yb;
        run_next = xb - xa;
        if (yb_v <= ya_v) begin
            rise_next = ya_v - yb_v;
            oct_next  = (rise_next < run_next || rise_next == '0) ? OCT_X_DOWN : OCT_Y_DOWN;
        end else begin
            rise_next = yb_v - ya_v;
            oct_next  = (rise_next < run_next) ? OCT_X_UP : OCT_Y_UP;
        end
        run_ext  = DW'(signed'({1'b0, run_next}));
        rise_ext = DW'(signed'({1'b0, rise_next}));
        if (oct_next == OCT_X_DOWN || oct_next == OCT_X_UP) begin
            dec_load = (rise_ext <<< 1) - run_ext;
        end else begin
            dec_load = (run_ext <<< 1) - rise_ext;
        end
    end

    always_comb begin
        x_major  = (oct_reg == OCT_X_DOWN) || (oct_reg == OCT_X_UP);
        diag     = !dec_reg[DW-1];
        cur_run  = DW'(signed'({1'b0, run_reg}));
        cur_rise = DW'(signed'({1'b0, rise_reg}));
        adv_x    = cur_x_reg;
        adv_y    = cur_y_reg;
        if (x_major) begin
            adv_x = cur_x_reg + COORD_ONE;
            if (diag) begin
                adv_y   = (oct_reg == OCT_X_DOWN) ? cur_y_reg - COORD_ONE
                                                  : cur_y_reg + COORD_ONE;
                dec_adv = dec_reg + ((cur_rise - cur_run) <<< 1);
            end else begin
                dec_adv = dec_reg + (cur_rise <<< 1);
            end
        end else begin
            adv_y = (oct_reg == OCT_Y_DOWN) ? cur_y_reg - COORD_ONE : cur_y_reg + COORD_ONE;
            if (diag) begin
                adv_x   = cur_x_reg + COORD_ONE;
                dec_adv = dec_reg + ((cur_run - cur_rise) <<< 1);
            end else begin
                dec_adv = dec_reg + (cur_run <<< 1);
            end
        end
        status.last_cur = x_major ? (cur_x_reg == tgt_x_reg) : (cur_y_reg == tgt_y_reg);
        status.last_adv = x_major ? (adv_x == tgt_x_reg) : (adv_y == tgt_y_reg);
    end

    assign step_x    = cmd.advance ? adv_x : cur_x_reg;
    assign step_y    = cmd.advance ? adv_y : cur_y_reg;
    assign step_last = cmd.advance ? status.last_adv : status.last_cur;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_x_reg <= xa;
            cur_y_reg <= ya_v;
            tgt_x_reg <= xb;
            tgt_y_reg <= yb_v;
            run_reg   <= run_next;
            rise_reg  <= rise_next;
            dec_reg   <= dec_load;
            oct_reg   <= oct_next;
        end else if (cmd.advance) begin
            cur_x_reg <= adv_x;
            cur_y_reg <= adv_y;
            dec_reg   <= dec_adv;
        end
        if (cmd.emit) begin
            pix_x_reg     <= cmd.blank ? '0 : step_x;
            pix_y_reg     <= cmd.blank ? '0 : step_y;
            pix_valid_reg <= !cmd.blank;
            pix_last_reg  <= !cmd.blank && step_last;
        end
    end

    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign pixel_valid = pix_valid_reg;
    assign last_pixel  = pix_last_reg;

endmodule

// File: rtl/core/midpoint_line_rasterizer.sv
// channel   direction  ports
// s_        in         s_valid s_ready s_opcode s_x_first s_y_first s_x_second s_y_second
// m_        out        m_valid m_ready m_pixel_x m_pixel_y m_pixel_valid m_last_pixel
//
// one item per cycle while s_ready is high: a load or a pixel step is combinational logic ahead of the state registers
// a step item gives one result in the cycle after it is taken, a load item gives none
// input is taken while the output register is empty or being drained the same cycle
// synchronous active-low reset leaves the block idle, a step then returns an invalid pixel
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [COORD_BITS-1:0] s_x_first,
    input  logic [COORD_BITS-1:0] s_y_first,
    input  logic [COORD_BITS-1:0] s_x_second,
    input  logic [COORD_BITS-1:0] s_y_second,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic                  m_pixel_valid,
    output logic                  m_last_pixel
);
    import mlr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mlr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    mlr_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .status      (status),
        .x_first     (s_x_first),
        .y_first     (s_y_first),
        .x_second    (s_x_second),
        .y_second    (s_y_second),
        .pixel_x     (m_pixel_x),
        .pixel_y     (m_pixel_y),
        .pixel_valid (m_pixel_valid),
        .last_pixel  (m_last_pixel)
    );

endmodule
